// ===== src/hom_pkg.sv =====
package hom_pkg;

    // Position word width; computed targets saturate to this signed range
    localparam int POSITION_BITS = 32;

    // Field widths
    localparam int TIME_W     = 32;
    localparam int SPEED_W    = 20;
    localparam int DISTCFG_W  = 24;
    localparam int VEL_W      = SPEED_W + 1;
    localparam int OUT_POS_W  = 32;
    localparam int IN_POS_W   = 32;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 3;

    // Release travel limit is 4 * backoff + extra, so two more bits and a carry
    localparam int REL_W  = DISTCFG_W + 3;
    localparam int DIST_W = (POSITION_BITS + 1 > REL_W) ? POSITION_BITS + 1 : REL_W;

    localparam int TOL_UM           = 50;
    localparam int RELEASE_EXTRA_UM = 1000;

    // Stream payload widths; the tdata words are padded to whole bytes
    localparam int S_TDATA_W = 72;
    localparam int M_TDATA_W = 64;
    localparam int M_TUSER_W = 2;

    typedef logic signed [POSITION_BITS-1:0] pos_t;
    typedef logic signed [VEL_W-1:0]         vel_t;
    typedef logic [DIST_W-1:0]               dist_t;

    typedef enum logic [3:0] {
        PH_IDLE       = 4'd0,
        PH_CHECK      = 4'd1,
        PH_RELEASE    = 4'd2,
        PH_SEEK_FAST  = 4'd3,
        PH_BRAKE_FAST = 4'd4,
        PH_BACKOFF    = 4'd5,
        PH_SEEK_SLOW  = 4'd6,
        PH_BRAKE_SLOW = 4'd7,
        PH_SET_ZERO   = 4'd8,
        PH_TO_OFFSET  = 4'd9,
        PH_READY      = 4'd10,
        PH_FAULT      = 4'd11
    } phase_t;

    typedef enum logic [2:0] {
        FLT_NONE         = 3'd0,
        FLT_TIMEOUT      = 3'd1,
        FLT_NOT_RELEASED = 3'd2,
        FLT_MAX_DIST     = 3'd3,
        FLT_NEVER        = 3'd4
    } fault_t;

    typedef enum logic [1:0] {
        MK_STOP    = 2'd0,
        MK_VEL     = 2'd1,
        MK_MOVE_TO = 2'd2
    } move_kind_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SEEK_NEGATIVE     = 3'd0,
        CFG_FAST_SPEED        = 3'd1,
        CFG_SLOW_SPEED        = 3'd2,
        CFG_BACKOFF           = 3'd3,
        CFG_MAX_SEARCH        = 3'd4,
        CFG_REST_OFFSET       = 3'd5,
        CFG_TIMEOUT           = 3'd6,
        CFG_SENSOR_ACTIVE_LOW = 3'd7
    } cfg_index_t;

    // Register defaults
    localparam logic [SPEED_W-1:0]   FAST_SPEED_RST  = SPEED_W'(20000);
    localparam logic [SPEED_W-1:0]   SLOW_SPEED_RST  = SPEED_W'(2000);
    localparam logic [DISTCFG_W-1:0] BACKOFF_RST     = DISTCFG_W'(3000);
    localparam logic [DISTCFG_W-1:0] MAX_SEARCH_RST  = DISTCFG_W'(500000);
    localparam logic [DISTCFG_W-1:0] REST_OFFSET_RST = DISTCFG_W'(1000);
    localparam logic [TIME_W-1:0]    TIMEOUT_RST     = TIME_W'(30000);

    typedef struct packed {
        logic                 seek_negative;
        logic [SPEED_W-1:0]   fast_speed_um_s;
        logic [SPEED_W-1:0]   slow_speed_um_s;
        logic [DISTCFG_W-1:0] backoff_um;
        logic [DISTCFG_W-1:0] max_search_um;
        logic [DISTCFG_W-1:0] rest_offset_um;
        logic [TIME_W-1:0]    timeout_ms;
        logic                 sensor_active_low;
    } cfg_t;

    typedef struct packed {
        logic                       command;
        logic [TIME_W-1:0]          time_ms;
        logic                       sensor_raw;
        logic signed [IN_POS_W-1:0] axis_position_um;
        logic                       motor_moving;
    } item_t;

    typedef struct packed {
        move_kind_t                  move_kind;
        vel_t                        velocity_um_s;
        logic signed [OUT_POS_W-1:0] target_um;
        phase_t                      phase;
        fault_t                      fault_code;
    } result_t;

    typedef struct packed {
        phase_t            phase;
        fault_t            fault;
        logic [TIME_W-1:0] start_time;
        pos_t              start_position;
        pos_t              trigger_position;
        pos_t              backoff_target;
        pos_t              zero_position;
        pos_t              offset_target;
    } hstate_t;

endpackage

// ===== src/axis_homing_sequencer.sv =====
// A request is captured in the input register, stepped and its result captured in the result register.
// One request per cycle while the result slot is free (a start request needs none), through the single
// step stage that sits between the input register and the result register.
// A start request updates the sequence and produces no result.
// Reset: synchronous, active-low aresetn; sequence goes idle with no fault, the
// configuration registers take their defaults, payload registers are not cleared.
module axis_homing_sequencer
    import hom_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // Request channel
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // time_ms[31:0], sensor_raw[32], axis_position_um[64:33], motor_moving[65], zero[71:66]
    input  logic [S_TDATA_W-1:0]  s_tdata,
    // command[0]
    input  logic                  s_tuser,
    // Result channel
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // velocity_um_s[20:0], target_um[52:21], phase[56:53], fault_code[59:57], zero[63:60]
    output logic [M_TDATA_W-1:0]  m_tdata,
    // move_kind[1:0]
    output logic [M_TUSER_W-1:0]  m_tuser,
    // Configuration write port
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    cfg_t    cfg;
    item_t   in_item_reg;
    logic    in_valid_reg;
    logic    in_valid_next;
    hstate_t st_reg;
    hstate_t st_next;
    result_t step_res;
    logic    step_emit;
    result_t out_reg;
    logic    out_valid_reg;
    logic    out_valid_next;
    logic    out_free;
    logic    fire;
    logic    s_fire;

    hom_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_index_t'(cfg_addr)),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    hom_step u_step (
        .cfg     (cfg),
        .st      (st_reg),
        .item    (in_item_reg),
        .st_next (st_next),
        .res     (step_res),
        .emit    (step_emit)
    );

    // A start request needs no result slot; an update needs a free one
    assign out_free = !out_valid_reg || m_tready;
    assign fire     = in_valid_reg && (in_item_reg.command || out_free);
    assign s_tready = !in_valid_reg || fire;
    assign s_fire   = s_tvalid && s_tready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_fire) begin
            in_valid_next = 1'b1;
        end else if (fire) begin
            in_valid_next = 1'b0;
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg && !m_tready;
        if (fire && step_emit) begin
            out_valid_next = 1'b1;
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg            <= 1'b0;
            out_valid_reg           <= 1'b0;
            st_reg.phase            <= PH_IDLE;
            st_reg.fault            <= FLT_NONE;
            st_reg.start_time       <= '0;
            st_reg.start_position   <= '0;
            st_reg.trigger_position <= '0;
            st_reg.backoff_target   <= '0;
            st_reg.zero_position    <= '0;
            st_reg.offset_target    <= '0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (fire) begin
                st_reg <= st_next;
            end
        end
    end

    // Capture the request and the result
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_item_reg.command          <= s_tuser;
            in_item_reg.time_ms          <= s_tdata[31:0];
            in_item_reg.sensor_raw       <= s_tdata[32];
            in_item_reg.axis_position_um <= s_tdata[64:33];
            in_item_reg.motor_moving     <= s_tdata[65];
        end
        if (fire && step_emit) begin
            out_reg <= step_res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.move_kind;
    assign m_tdata  = {4'b0000, out_reg.fault_code, out_reg.phase,
                       out_reg.target_um, out_reg.velocity_um_s};

`ifndef ASSERT_OFF
    // A start request always goes through and arms the sequence
    a_start_arms: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && in_item_reg.command) |=>
            (st_reg.phase == PH_CHECK && st_reg.fault == FLT_NONE))
        else $error("start request did not arm the sequence");

    // Fault phase and a fault code go together
    a_fault_consistent: assert property (@(posedge aclk) disable iff (!aresetn)
        (st_reg.phase == PH_FAULT) == (st_reg.fault != FLT_NONE))
        else $error("fault phase and fault code disagree");

    // State moves only when a request is processed
    a_state_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !fire |=> (st_reg == $past(st_reg)))
        else $error("sequence state changed without a request");

    // Only velocity commands carry a velocity
    a_vel_only_for_vel: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_reg.move_kind != MK_VEL) |-> (out_reg.velocity_um_s == '0))
        else $error("velocity set on a non-velocity command");
`endif

endmodule

// ===== src/hom_cfg.sv =====
module hom_cfg
    import hom_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  cfg_index_t            cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Decode the write into the addressed register
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_addr)
                CFG_SEEK_NEGATIVE:     cfg_next.seek_negative     = cfg_wdata[0];
                CFG_FAST_SPEED:        cfg_next.fast_speed_um_s   = cfg_wdata[SPEED_W-1:0];
                CFG_SLOW_SPEED:        cfg_next.slow_speed_um_s   = cfg_wdata[SPEED_W-1:0];
                CFG_BACKOFF:           cfg_next.backoff_um        = cfg_wdata[DISTCFG_W-1:0];
                CFG_MAX_SEARCH:        cfg_next.max_search_um     = cfg_wdata[DISTCFG_W-1:0];
                CFG_REST_OFFSET:       cfg_next.rest_offset_um    = cfg_wdata[DISTCFG_W-1:0];
                CFG_TIMEOUT:           cfg_next.timeout_ms        = cfg_wdata[TIME_W-1:0];
                CFG_SENSOR_ACTIVE_LOW: cfg_next.sensor_active_low = cfg_wdata[0];
                default:               cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.seek_negative     <= 1'b0;
            cfg_reg.fast_speed_um_s   <= FAST_SPEED_RST;
            cfg_reg.slow_speed_um_s   <= SLOW_SPEED_RST;
            cfg_reg.backoff_um        <= BACKOFF_RST;
            cfg_reg.max_search_um     <= MAX_SEARCH_RST;
            cfg_reg.rest_offset_um    <= REST_OFFSET_RST;
            cfg_reg.timeout_ms        <= TIMEOUT_RST;
            cfg_reg.sensor_active_low <= 1'b0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== src/hom_step.sv =====
module hom_step
    import hom_pkg::*;
(
    input  cfg_t    cfg,
    input  hstate_t st,
    input  item_t   item,
    output hstate_t st_next,
    output result_t res,
    output logic    emit
);

    // Signed velocity from a speed magnitude, negated on request
    function automatic vel_t speed_vel(input logic [SPEED_W-1:0] speed, input logic neg);
        logic [VEL_W-1:0] v;
        v = {1'b0, speed};
        return neg ? vel_t'(-v) : vel_t'(v);
    endfunction

    // Absolute distance between two positions
    function automatic dist_t dist_of(input pos_t a, input pos_t b);
        logic signed [POSITION_BITS:0] d;
        logic [POSITION_BITS:0]        m;
        d = {a[POSITION_BITS-1], a} - {b[POSITION_BITS-1], b};
        m = d[POSITION_BITS] ? -d : d;
        return DIST_W'(m);
    endfunction

    // base +/- mag, saturated to the signed position range
    function automatic pos_t offset_sat(input pos_t base, input logic [DISTCFG_W-1:0] mag,
                                        input logic add);
        logic [POSITION_BITS:0] ext;
        logic [POSITION_BITS:0] magw;
        logic [POSITION_BITS:0] w;
        ext  = {base[POSITION_BITS-1], base};
        magw = (POSITION_BITS + 1)'(mag);
        w    = add ? ext + magw : ext - magw;
        if (w[POSITION_BITS] != w[POSITION_BITS-1]) begin
            return w[POSITION_BITS] ? pos_t'({1'b1, {(POSITION_BITS-1){1'b0}}})
                                    : pos_t'({1'b0, {(POSITION_BITS-1){1'b1}}});
        end
        return pos_t'(w[POSITION_BITS-1:0]);
    endfunction

    // Low 32 bits of a position, sign-extended first where it is narrower
    function automatic logic signed [OUT_POS_W-1:0] to_out(input pos_t p);
        logic signed [63:0] e;
        e = 64'(p);
        return e[OUT_POS_W-1:0];
    endfunction

    logic              sensor;
    pos_t              pos;
    logic [TIME_W-1:0] elapsed;
    logic              timed_out;
    vel_t              vel_fast_fwd;
    vel_t              vel_slow_fwd;
    vel_t              vel_slow_rev;
    dist_t             d_start;
    dist_t             d_backoff;
    dist_t             d_offset;
    dist_t             rel_limit;
    dist_t             max_dist;
    pos_t              backoff_tgt;
    pos_t              rest_tgt;
    logic              fail;
    fault_t            fail_code;
    move_kind_t        kind;
    vel_t              vel;
    pos_t              tgt;

    // Shared measurements for every phase
    always_comb begin
        sensor       = item.sensor_raw ^ cfg.sensor_active_low;
        pos          = pos_t'(item.axis_position_um);
        elapsed      = item.time_ms - st.start_time;
        timed_out    = elapsed > cfg.timeout_ms;
        vel_fast_fwd = speed_vel(cfg.fast_speed_um_s, cfg.seek_negative);
        vel_slow_fwd = speed_vel(cfg.slow_speed_um_s, cfg.seek_negative);
        vel_slow_rev = speed_vel(cfg.slow_speed_um_s, !cfg.seek_negative);
        d_start      = dist_of(pos, st.start_position);
        d_backoff    = dist_of(pos, st.backoff_target);
        d_offset     = dist_of(pos, st.offset_target);
        rel_limit    = DIST_W'({cfg.backoff_um, 2'b00}) + DIST_W'(RELEASE_EXTRA_UM);
        max_dist     = DIST_W'(cfg.max_search_um);
        // Move away from the sensor: add when seeking toward negative
        backoff_tgt  = offset_sat(st.trigger_position, cfg.backoff_um, cfg.seek_negative);
        rest_tgt     = offset_sat(st.zero_position, cfg.rest_offset_um, cfg.seek_negative);
    end

    // Step the sequence by one request
    always_comb begin
        st_next   = st;
        kind      = MK_STOP;
        vel       = '0;
        tgt       = '0;
        emit      = 1'b1;
        fail      = 1'b0;
        fail_code = FLT_NONE;

        if (item.command) begin
            // Restart: arm the sequence, no command out
            st_next.phase          = PH_CHECK;
            st_next.fault          = FLT_NONE;
            st_next.start_time     = item.time_ms;
            st_next.start_position = '0;
            emit                   = 1'b0;
        end else begin
            case (st.phase)
                PH_CHECK: begin
                    st_next.start_position = pos;
                    kind = MK_VEL;
                    if (sensor) begin
                        st_next.phase = PH_RELEASE;
                        vel = vel_slow_rev;
                    end else begin
                        st_next.phase = PH_SEEK_FAST;
                        vel = vel_fast_fwd;
                    end
                end
                PH_RELEASE: begin
                    if (timed_out) begin
                        fail = 1'b1;
                        fail_code = FLT_TIMEOUT;
                    end else if (d_start > rel_limit) begin
                        fail = 1'b1;
                        fail_code = FLT_NOT_RELEASED;
                    end else if (!sensor) begin
                        st_next.trigger_position = pos;
                        st_next.phase = PH_BRAKE_FAST;
                    end else begin
                        kind = MK_VEL;
                        vel  = vel_slow_rev;
                    end
                end
                PH_SEEK_FAST: begin
                    if (timed_out) begin
                        fail = 1'b1;
                        fail_code = FLT_TIMEOUT;
                    end else if (d_start > max_dist) begin
                        fail = 1'b1;
                        fail_code = FLT_MAX_DIST;
                    end else if (sensor) begin
                        st_next.trigger_position = pos;
                        st_next.phase = PH_BRAKE_FAST;
                    end else begin
                        kind = MK_VEL;
                        vel  = vel_fast_fwd;
                    end
                end
                PH_BRAKE_FAST: begin
                    if (timed_out) begin
                        fail = 1'b1;
                        fail_code = FLT_TIMEOUT;
                    end else if (!item.motor_moving) begin
                        st_next.backoff_target = backoff_tgt;
                        st_next.phase = PH_BACKOFF;
                        kind = MK_MOVE_TO;
                        tgt  = backoff_tgt;
                    end
                end
                PH_BACKOFF: begin
                    if (timed_out) begin
                        fail = 1'b1;
                        fail_code = FLT_TIMEOUT;
                    end else if (d_backoff < DIST_W'(TOL_UM) && !item.motor_moving) begin
                        if (sensor) begin
                            fail = 1'b1;
                            fail_code = FLT_NOT_RELEASED;
                        end else begin
                            st_next.phase = PH_SEEK_SLOW;
                            kind = MK_VEL;
                            vel  = vel_slow_fwd;
                        end
                    end else begin
                        kind = MK_MOVE_TO;
                        tgt  = st.backoff_target;
                    end
                end
                PH_SEEK_SLOW: begin
                    if (timed_out) begin
                        fail = 1'b1;
                        fail_code = FLT_TIMEOUT;
                    end else if (d_start > max_dist) begin
                        fail = 1'b1;
                        fail_code = FLT_NEVER;
                    end else if (sensor) begin
                        st_next.zero_position = pos;
                        st_next.phase = PH_BRAKE_SLOW;
                    end else begin
                        kind = MK_VEL;
                        vel  = vel_slow_fwd;
                    end
                end
                PH_BRAKE_SLOW: begin
                    if (timed_out) begin
                        fail = 1'b1;
                        fail_code = FLT_TIMEOUT;
                    end else if (!item.motor_moving) begin
                        st_next.phase = PH_SET_ZERO;
                    end
                end
                PH_SET_ZERO: begin
                    st_next.offset_target = rest_tgt;
                    st_next.phase = PH_TO_OFFSET;
                    kind = MK_MOVE_TO;
                    tgt  = rest_tgt;
                end
                PH_TO_OFFSET: begin
                    if (timed_out) begin
                        fail = 1'b1;
                        fail_code = FLT_TIMEOUT;
                    end else if (d_offset < DIST_W'(TOL_UM) && !item.motor_moving) begin
                        st_next.phase = PH_READY;
                    end else begin
                        kind = MK_MOVE_TO;
                        tgt  = st.offset_target;
                    end
                end
                // Idle, ready, fault and unused codes: hold and stop
                default: begin
                    kind = MK_STOP;
                end
            endcase
        end

        // Drop into the fault phase with a stop command
        if (fail) begin
            st_next.phase = PH_FAULT;
            st_next.fault = fail_code;
            kind = MK_STOP;
            vel  = '0;
            tgt  = '0;
        end

        res.move_kind     = kind;
        res.velocity_um_s = vel;
        res.target_um     = to_out(tgt);
        res.phase         = st_next.phase;
        res.fault_code    = st_next.fault;
    end

endmodule
